// ===== src/opl_rsd_pkg.sv =====
`timescale 1ns / 1ps

package opl_rsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int DELAY_W = 17;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = 40;   // 34 payload bits padded to whole bytes
    localparam int TUSER_W = 3;

    localparam logic [BYTE_W-1:0] CODE_CHIP0  = 8'h02;
    localparam logic [BYTE_W-1:0] CODE_CHIP1  = 8'h03;
    localparam logic [BYTE_W-1:0] CODE_ESCAPE = 8'h04;

    localparam logic [BYTE_W-1:0] SHORT_DELAY_RESET = 8'h00;
    localparam logic [BYTE_W-1:0] LONG_DELAY_RESET  = 8'h01;

    typedef enum logic {
        CFG_SHORT_DELAY = 1'b0,
        CFG_LONG_DELAY  = 1'b1
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_DELAY = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               chip_select;
        logic [BYTE_W-1:0]  reg_index;
        logic [BYTE_W-1:0]  reg_value;
        logic [DELAY_W-1:0] delay_ms;
        logic               final_res;
        logic               truncated;
    } result_t;

endpackage

// ===== src/opl_register_stream_decoder.sv =====
`timescale 1ns / 1ps

// A result is registered and appears on m_ in the cycle after the stream byte that completes it is taken.
// Throughput: one byte per cycle; s_tready stays high while the output register is empty
// or is being drained in the same cycle, so the result register and m_tready set the pace.
// Reset (aresetn low, synchronous): parser waits for a command byte, chip 0 is selected,
// the delay codes return to 0 and 1, and no result is pending.
module opl_register_stream_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [opl_rsd_pkg::BYTE_W-1:0]  cfg_data,
    // command byte stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [opl_rsd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] stream_byte
    input  logic                            s_tlast,   // is_last
    // decoded results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] chip_select, [8:1] reg_index, [16:9] reg_value, [33:17] delay_ms, [39:34] zero
    output logic [opl_rsd_pkg::TDATA_W-1:0] m_tdata,
    output logic [opl_rsd_pkg::TUSER_W-1:0] m_tuser,   // [1:0] kind, [2] truncated
    output logic                            m_tlast    // final_res
);

    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_SDELAY    = 3'd1,
        PH_LDELAY_LO = 3'd2,
        PH_LDELAY_HI = 3'd3,
        PH_ESC_INDEX = 3'd4,
        PH_VALUE     = 3'd5
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic                             chip_reg, chip_next;
    logic [opl_rsd_pkg::BYTE_W-1:0]   index_reg, index_next;
    logic [opl_rsd_pkg::BYTE_W-1:0]   delay_lo_reg, delay_lo_next;
    logic [opl_rsd_pkg::BYTE_W-1:0]   short_code_reg;
    logic [opl_rsd_pkg::BYTE_W-1:0]   long_code_reg;
    logic                             out_valid_reg;
    opl_rsd_pkg::result_t             out_reg, res_next;
    logic                             emit;
    logic                             s_xfer;
    logic                             cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;

    always_comb begin
        phase_next    = PH_CMD;
        chip_next     = chip_reg;
        index_next    = index_reg;
        delay_lo_next = delay_lo_reg;
        emit          = 1'b0;
        res_next      = '0;
        res_next.final_res = s_tlast;

        case (phase_reg)
            PH_SDELAY: begin
                emit              = 1'b1;
                res_next.kind     = opl_rsd_pkg::KIND_DELAY;
                res_next.delay_ms = {1'b0, 8'h00, s_tdata} + 17'd1;
            end
            PH_LDELAY_LO: begin
                delay_lo_next = s_tdata;
                phase_next    = PH_LDELAY_HI;
            end
            PH_LDELAY_HI: begin
                emit              = 1'b1;
                res_next.kind     = opl_rsd_pkg::KIND_DELAY;
                res_next.delay_ms = {1'b0, s_tdata, delay_lo_reg} + 17'd1;
            end
            PH_ESC_INDEX: begin
                index_next = s_tdata;
                phase_next = PH_VALUE;
            end
            PH_VALUE: begin
                emit                 = 1'b1;
                res_next.kind        = opl_rsd_pkg::KIND_WRITE;
                res_next.chip_select = chip_reg;
                res_next.reg_index   = index_reg;
                res_next.reg_value   = s_tdata;
            end
            default: begin
                // delay codes take priority over the fixed command bytes
                if (s_tdata == short_code_reg) begin
                    phase_next = PH_SDELAY;
                end else if (s_tdata == long_code_reg) begin
                    phase_next = PH_LDELAY_LO;
                end else if (s_tdata == opl_rsd_pkg::CODE_CHIP0 ||
                             s_tdata == opl_rsd_pkg::CODE_CHIP1) begin
                    chip_next = s_tdata[0];
                    if (s_tlast) begin
                        emit          = 1'b1;
                        res_next.kind = opl_rsd_pkg::KIND_END;
                    end
                end else if (s_tdata == opl_rsd_pkg::CODE_ESCAPE) begin
                    phase_next = PH_ESC_INDEX;
                end else begin
                    index_next = s_tdata;
                    phase_next = PH_VALUE;
                end
            end
        endcase

        if (s_tlast) begin
            // stream ends inside a partial command: drop it
            if (!emit) begin
                emit               = 1'b1;
                res_next.kind      = opl_rsd_pkg::KIND_END;
                res_next.truncated = 1'b1;
            end
            phase_next = PH_CMD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_CMD;
            chip_reg       <= 1'b0;
            index_reg      <= '0;
            delay_lo_reg   <= '0;
            short_code_reg <= opl_rsd_pkg::SHORT_DELAY_RESET;
            long_code_reg  <= opl_rsd_pkg::LONG_DELAY_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                case (opl_rsd_pkg::cfg_index_t'(cfg_index))
                    opl_rsd_pkg::CFG_SHORT_DELAY: short_code_reg <= cfg_data;
                    opl_rsd_pkg::CFG_LONG_DELAY:  long_code_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_xfer) begin
                phase_reg    <= phase_next;
                chip_reg     <= chip_next;
                index_reg    <= index_next;
                delay_lo_reg <= delay_lo_next;
            end
            if (s_xfer && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_xfer && emit) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.delay_ms, out_reg.reg_value, out_reg.reg_index,
                       out_reg.chip_select};
    assign m_tuser  = {out_reg.truncated, out_reg.kind};
    assign m_tlast  = out_reg.final_res;

    // the last byte always closes the stream back to command parsing
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tlast |=> phase_reg == PH_CMD)
        else $error("parser not back at command phase after last byte");

    // the last byte always yields exactly one result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_tlast |=> out_valid_reg && out_reg.final_res)
        else $error("last byte did not produce a final result");

    // truncation is only reported on an end result of the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.truncated |->
            out_reg.kind == opl_rsd_pkg::KIND_END && out_reg.final_res)
        else $error("truncated flag on a non-end result");

    // a delay result is never zero length; other kinds carry no delay
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            ((out_reg.kind == opl_rsd_pkg::KIND_DELAY) == (out_reg.delay_ms != '0)))
        else $error("delay field inconsistent with result kind");

    // a partially parsed command holds while no byte is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer && !cfg_xfer |=> $stable(phase_reg) && $stable(chip_reg))
        else $error("parse state moved without a stream transfer");

endmodule

// ===== sim/opl_rsd_checker.sv =====
`timescale 1ns / 1ps

module opl_rsd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [opl_rsd_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [opl_rsd_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [opl_rsd_pkg::TDATA_W-1:0] m_tdata,
    input  logic [opl_rsd_pkg::TUSER_W-1:0] m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              outstanding
);

    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_SHORT_LEN = 3'd1,
        PH_LONG_LO   = 3'd2,
        PH_LONG_HI   = 3'd3,
        PH_ESC_INDEX = 3'd4,
        PH_VALUE     = 3'd5
    } parse_phase_t;

    logic [opl_rsd_pkg::BYTE_W-1:0] short_code;
    logic [opl_rsd_pkg::BYTE_W-1:0] long_code;
    parse_phase_t                   phase;
    logic                           chip;
    logic [opl_rsd_pkg::BYTE_W-1:0] held_index;
    logic [opl_rsd_pkg::BYTE_W-1:0] delay_low;

    opl_rsd_pkg::result_t expected_results[$];
    opl_rsd_pkg::result_t got;
    opl_rsd_pkg::result_t want;
    int                   mismatches = 0;

    task automatic decode_stream_byte(input logic [opl_rsd_pkg::BYTE_W-1:0] b,
                                      input logic last);
        opl_rsd_pkg::result_t r;
        logic                 have;
        parse_phase_t         nxt;
        r    = '0;
        have = 1'b0;
        nxt  = PH_CMD;
        case (phase)
            PH_SHORT_LEN: begin
                r.kind     = opl_rsd_pkg::KIND_DELAY;
                r.delay_ms = {{(opl_rsd_pkg::DELAY_W-opl_rsd_pkg::BYTE_W){1'b0}}, b} + 1'b1;
                have       = 1'b1;
            end
            PH_LONG_LO: begin
                delay_low = b;
                nxt       = PH_LONG_HI;
            end
            PH_LONG_HI: begin
                r.kind     = opl_rsd_pkg::KIND_DELAY;
                r.delay_ms = {1'b0, b, delay_low} + 1'b1;
                have       = 1'b1;
            end
            PH_ESC_INDEX: begin
                held_index = b;
                nxt        = PH_VALUE;
            end
            PH_VALUE: begin
                r.kind        = opl_rsd_pkg::KIND_WRITE;
                r.chip_select = chip;
                r.reg_index   = held_index;
                r.reg_value   = b;
                have          = 1'b1;
            end
            default: begin
                // delay codes take priority over the fixed codes
                if (b == short_code) begin
                    nxt = PH_SHORT_LEN;
                end else if (b == long_code) begin
                    nxt = PH_LONG_LO;
                end else if (b == opl_rsd_pkg::CODE_CHIP0 || b == opl_rsd_pkg::CODE_CHIP1) begin
                    chip = (b == opl_rsd_pkg::CODE_CHIP1);
                    if (last) begin
                        r.kind = opl_rsd_pkg::KIND_END;
                        have   = 1'b1;
                    end
                end else if (b == opl_rsd_pkg::CODE_ESCAPE) begin
                    nxt = PH_ESC_INDEX;
                end else begin
                    held_index = b;
                    nxt        = PH_VALUE;
                end
            end
        endcase
        if (last) begin
            // stream ended inside a command: partial command dropped
            if (!have) begin
                r           = '0;
                r.kind      = opl_rsd_pkg::KIND_END;
                r.truncated = 1'b1;
                have        = 1'b1;
            end
            r.final_res = 1'b1;
            nxt         = PH_CMD;
        end
        phase = nxt;
        if (have)
            expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input logic has_want,
                                   input opl_rsd_pkg::result_t w,
                                   input opl_rsd_pkg::result_t g,
                                   input logic [opl_rsd_pkg::TDATA_W-1:0] raw);
        mismatches++;
        if (mismatches <= 10) begin
            if (has_want)
                $display("%0t mismatch: exp kind=%0d chip=%0d idx=%02h val=%02h dly=%0d fin=%0b tr=%0b",
                         $realtime, w.kind, w.chip_select, w.reg_index, w.reg_value,
                         w.delay_ms, w.final_res, w.truncated);
            else
                $display("%0t mismatch: result transfer with nothing expected", $realtime);
            $display("%0t   got kind=%0d chip=%0d idx=%02h val=%02h dly=%0d fin=%0b tr=%0b tdata=%h",
                     $realtime, g.kind, g.chip_select, g.reg_index, g.reg_value,
                     g.delay_ms, g.final_res, g.truncated, raw);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            short_code = opl_rsd_pkg::SHORT_DELAY_RESET;
            long_code  = opl_rsd_pkg::LONG_DELAY_RESET;
            phase      = PH_CMD;
            chip       = 1'b0;
            held_index = '0;
            delay_low  = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == opl_rsd_pkg::CFG_SHORT_DELAY)
                    short_code = cfg_data;
                else
                    long_code = cfg_data;
            end
            // results first: a result taken now was caused by an earlier byte
            if (m_tvalid && m_tready) begin
                got.kind        = opl_rsd_pkg::kind_t'(m_tuser[1:0]);
                got.truncated   = m_tuser[2];
                got.chip_select = m_tdata[0];
                got.reg_index   = m_tdata[8:1];
                got.reg_value   = m_tdata[16:9];
                got.delay_ms    = m_tdata[33:17];
                got.final_res   = m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch(1'b0, '0, got, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[opl_rsd_pkg::TDATA_W-1:34] !== '0)
                        report_mismatch(1'b1, want, got, m_tdata);
                end
            end
            if (s_tvalid && s_tready)
                decode_stream_byte(s_tdata, s_tlast);
        end
        outstanding <= expected_results.size();
        fail_count  <= mismatches;
    end

endmodule

// ===== sim/tb_opl_register_stream_decoder.sv =====
`timescale 1ns / 1ps

module tb_opl_register_stream_decoder;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_index = opl_rsd_pkg::CFG_SHORT_DELAY;
    logic [opl_rsd_pkg::BYTE_W-1:0]  cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [opl_rsd_pkg::BYTE_W-1:0]  s_tdata   = '0;    // [7:0] stream_byte
    logic                            s_tlast   = 1'b0;  // is_last
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // [0] chip_select, [8:1] reg_index, [16:9] reg_value, [33:17] delay_ms
    logic [opl_rsd_pkg::TDATA_W-1:0] m_tdata;
    logic [opl_rsd_pkg::TUSER_W-1:0] m_tuser;           // [1:0] kind, [2] truncated
    logic                            m_tlast;           // final_res

    int fail_count;
    int outstanding;

    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             bytes_sent    = 0;
    logic [opl_rsd_pkg::BYTE_W-1:0] cur_short     = opl_rsd_pkg::SHORT_DELAY_RESET;
    logic [opl_rsd_pkg::BYTE_W-1:0] cur_long      = opl_rsd_pkg::LONG_DELAY_RESET;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    opl_register_stream_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    opl_rsd_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_byte(input logic [opl_rsd_pkg::BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    // lets the last result drain, then waits out any in-flight byte
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 || m_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_decoder_reg(input opl_rsd_pkg::cfg_index_t idx,
                                     input logic [opl_rsd_pkg::BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == opl_rsd_pkg::CFG_SHORT_DELAY)
            cur_short = val;
        else
            cur_long = val;
    endtask

    task automatic set_delay_codes(input logic [opl_rsd_pkg::BYTE_W-1:0] sc,
                                   input logic [opl_rsd_pkg::BYTE_W-1:0] lc);
        wait_drained();
        write_decoder_reg(opl_rsd_pkg::CFG_SHORT_DELAY, sc);
        write_decoder_reg(opl_rsd_pkg::CFG_LONG_DELAY, lc);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed commands with random payload; random early stream ends
    // cut commands short now and then
    task automatic stream_random_commands(input int n_bytes);
        int target;
        int pick;
        int len;
        logic [opl_rsd_pkg::BYTE_W-1:0] cmd[3];
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick = $urandom_range(9);
            cmd[0] = 8'($urandom_range(255));
            cmd[1] = 8'($urandom_range(255));
            cmd[2] = 8'($urandom_range(255));
            case (pick)
                0: begin cmd[0] = cur_short; len = 2; end
                1: begin cmd[0] = cur_long; len = 3; end
                2: begin cmd[0] = opl_rsd_pkg::CODE_CHIP0; len = 1; end
                3: begin cmd[0] = opl_rsd_pkg::CODE_CHIP1; len = 1; end
                4: begin cmd[0] = opl_rsd_pkg::CODE_ESCAPE; len = 3; end
                9: len = 1;
                default: len = 2;
            endcase
            for (int i = 0; i < len; i++)
                push_byte(cmd[i], $urandom_range(39) == 0);
        end
        push_byte(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        // {is_last, byte}, decoded with the reset delay codes
        logic [8:0] directed[24];
        directed = '{
            9'h000, 9'h0FF,            // short delay, longest
            9'h001, 9'h000, 9'h000,    // long delay, shortest
            9'h001, 9'h0FF, 9'h0FF,    // long delay, longest
            9'h003,                    // chip 1
            9'h0FF, 9'h000,            // plain write
            9'h004, 9'h002, 9'h0AA,    // escaped index
            9'h002,                    // chip 0
            9'h005, 9'h080,
            9'h000, 9'h107,            // delay completed by the last byte
            9'h103,                    // bank switch as the last byte
            9'h004, 9'h110,            // stream ends inside an escaped write
            9'h001, 9'h134             // stream ends inside a long delay
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            push_byte(directed[i][7:0], directed[i][8]);

        send_idle_pct = 10;
        recv_idle_pct = 60;
        set_delay_codes(8'hFF, 8'h00);
        stream_random_commands(150);

        send_idle_pct = 60;
        recv_idle_pct = 10;
        // equal codes that also shadow the chip 0 code
        set_delay_codes(opl_rsd_pkg::CODE_CHIP0, opl_rsd_pkg::CODE_CHIP0);
        stream_random_commands(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_delay_codes(opl_rsd_pkg::CODE_ESCAPE, opl_rsd_pkg::CODE_CHIP1);
        stream_random_commands(150);

        set_delay_codes(8'h01, 8'hFF);
        stream_random_commands(150);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
